/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/iasp_pkg.sv */
// ----------------------------------------------------------------------------
// iasp_pkg
// Shared types and character codes for the add/sub/paren expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package iasp_pkg;

  localparam int WORD_W  = 32;
  localparam int DIGIT_W = 4;

  // Character codes that carry meaning in an expression
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Queue between front and back (depth is a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_OPEN,
    OP_CLOSE,
    OP_ADD,
    OP_SUB,
    OP_SKIP
  } op_kind_t;

  // Classified character handed from front to back
  typedef struct packed {
    op_kind_t             kind;
    logic [DIGIT_W-1:0]   digit;
    logic                 last;
  } op_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     status;
  } out_t;

  // One saved stack frame: sign and partial sum in front of a '('
  typedef struct packed {
    logic              sign_add;
    logic [WORD_W-1:0] sum;
  } frame_t;

endpackage

`default_nettype wire

/* hw/rtl/iasp_queue.sv */
// ----------------------------------------------------------------------------
// iasp_queue
// Small FIFO of classified ops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module iasp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire iasp_pkg::op_t  push_op,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output iasp_pkg::op_t       pop_op
);

  iasp_pkg::op_t                     entries [iasp_pkg::QUEUE_DEPTH];
  logic [iasp_pkg::QUEUE_AW-1:0]     wptr;
  logic [iasp_pkg::QUEUE_AW-1:0]     rptr;
  logic [iasp_pkg::QUEUE_CW-1:0]     count;
  logic                              push_fire;
  logic                              pop_fire;

  assign push_ready = (count != iasp_pkg::QUEUE_CW'(iasp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_op     = entries[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_fire) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + iasp_pkg::QUEUE_CW'(push_fire) - iasp_pkg::QUEUE_CW'(pop_fire);
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iasp_front.sv */
// ----------------------------------------------------------------------------
// iasp_front
// Accepts characters, classifies them and holds the op in a stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module iasp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire iasp_pkg::in_t  item,
  output logic                op_valid,
  input  wire logic           op_ready,
  output iasp_pkg::op_t       op
);

  iasp_pkg::op_kind_t kind_c;
  logic               item_fire;

  // Classify the character
  always_comb begin
    kind_c = iasp_pkg::OP_SKIP;
    if (item.char_code inside {[iasp_pkg::CH_ZERO:iasp_pkg::CH_NINE]}) begin
      kind_c = iasp_pkg::OP_DIGIT;
    end else begin
      case (item.char_code)
        iasp_pkg::CH_OPEN:  kind_c = iasp_pkg::OP_OPEN;
        iasp_pkg::CH_CLOSE: kind_c = iasp_pkg::OP_CLOSE;
        iasp_pkg::CH_PLUS:  kind_c = iasp_pkg::OP_ADD;
        iasp_pkg::CH_MINUS: kind_c = iasp_pkg::OP_SUB;
        default:            kind_c = iasp_pkg::OP_SKIP;
      endcase
    end
  end

  assign item_ready = !op_valid || op_ready;
  assign item_fire  = item_valid && item_ready;

  // Hold the stage valid until the queue takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (item_fire) begin
      op_valid <= 1'b1;
    end else if (op_ready) begin
      op_valid <= 1'b0;
    end
  end

  // Load the classified word; '0'..'9' carry their value in the low nibble
  always_ff @(posedge clk) begin
    if (item_fire) begin
      op.kind  <= kind_c;
      op.digit <= item.char_code[iasp_pkg::DIGIT_W-1:0];
      op.last  <= item.last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iasp_back.sv */
// ----------------------------------------------------------------------------
// iasp_back
// Executes classified ops: running sum, pending number and paren stack.
// ----------------------------------------------------------------------------
`default_nettype none

module iasp_back #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           op_valid,
  output logic                op_ready,
  input  wire iasp_pkg::op_t  op,
  output logic                result_valid,
  input  wire logic           result_ready,
  output iasp_pkg::out_t      result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
  localparam int W = iasp_pkg::WORD_W;

  // Architectural state
  logic [W-1:0]  running_sum, running_sum_next;
  logic          sign_add, sign_add_next;
  logic [W-1:0]  pend, pend_next;
  logic          in_num, in_num_next;
  logic [DW-1:0] depth, depth_next;
  logic          ovf, ovf_next;

  // Stack: top frame in a register, the rest in memory, next-below prefetched
  iasp_pkg::frame_t tos, tos_next;
  iasp_pkg::frame_t nos;
  iasp_pkg::frame_t mem [STACK_DEPTH];
  logic [AW-1:0]    rd_addr;

  logic          out_free;
  logic          fire;
  logic          push;
  logic [W-1:0]  sum_commit;
  logic [W-1:0]  pend_scaled;
  logic [W-1:0]  res_value;
  logic          res_status;

  assign out_free = !result_valid || result_ready;
  assign op_ready = !op.last || out_free;
  assign fire     = op_valid && op_ready;

  // Commit the pending number with the current sign
  assign sum_commit = !in_num ? running_sum :
                      (sign_add ? running_sum + pend : running_sum - pend);

  // Times ten plus the new digit
  assign pend_scaled = (pend << 3) + (pend << 1) + W'(op.digit);

  always_comb begin
    running_sum_next = running_sum;
    sign_add_next    = sign_add;
    pend_next        = pend;
    in_num_next      = in_num;
    depth_next       = depth;
    ovf_next         = ovf;
    tos_next         = tos;
    push             = 1'b0;
    res_value        = '0;
    res_status       = 1'b0;
    if (fire) begin
      if (op.kind == iasp_pkg::OP_DIGIT) begin
        pend_next   = pend_scaled;
        in_num_next = 1'b1;
      end else begin
        pend_next        = '0;
        in_num_next      = 1'b0;
        running_sum_next = sum_commit;
      end
      case (op.kind)
        iasp_pkg::OP_OPEN: begin
          if (depth != DEPTH_MAX) begin
            push             = 1'b1;
            tos_next         = '{sign_add: sign_add, sum: sum_commit};
            depth_next       = depth + DW'(1);
            running_sum_next = '0;
            sign_add_next    = 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
        iasp_pkg::OP_CLOSE: begin
          // Unmatched close is dropped
          if (depth != '0) begin
            tos_next         = nos;
            depth_next       = depth - DW'(1);
            running_sum_next = tos.sign_add ? tos.sum + sum_commit : tos.sum - sum_commit;
          end
        end
        iasp_pkg::OP_ADD: sign_add_next = 1'b1;
        iasp_pkg::OP_SUB: sign_add_next = 1'b0;
        default: ;
      endcase
      // Close out the expression and return to the reset state
      if (op.last) begin
        res_value = !in_num_next ? running_sum_next :
                    (sign_add_next ? running_sum_next + pend_next
                                   : running_sum_next - pend_next);
        res_status       = ovf_next;
        running_sum_next = '0;
        sign_add_next    = 1'b1;
        pend_next        = '0;
        in_num_next      = 1'b0;
        depth_next       = '0;
        ovf_next         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sign_add    <= 1'b1;
      pend        <= '0;
      in_num      <= 1'b0;
      depth       <= '0;
      ovf         <= 1'b0;
    end else begin
      running_sum <= running_sum_next;
      sign_add    <= sign_add_next;
      pend        <= pend_next;
      in_num      <= in_num_next;
      depth       <= depth_next;
      ovf         <= ovf_next;
    end
  end

  // Hold the top frame
  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  // Spill the old top on push; prefetch the frame below the new top
  assign rd_addr = AW'(depth_next - DW'(2));

  always_ff @(posedge clk) begin
    if (push && depth != '0) begin
      mem[AW'(depth - DW'(1))] <= tos;
    end
    if (push) begin
      nos <= tos;
    end else begin
      nos <= mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && op.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && op.last) begin
      result.value  <= res_value;
      result.status <= res_status;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/infix_add_sub_paren_evaluator.sv */
// ----------------------------------------------------------------------------
// infix_add_sub_paren_evaluator
// Evaluates +, - and parentheses over decimal numbers, one character a word.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one ASCII character per
//   word with a last flag on the final character of an expression.
//   result channel (result_valid/result_ready/result) gives one word per
//   expression: the 32-bit wrapped value and a status bit that is set when
//   a '(' found the paren stack full.
//   Throughput: one character per cycle while no result stall holds the back
//   end. The top stack frame sits in a register and the frame below it is
//   prefetched from the stack memory every cycle, so back-to-back ')' need
//   no wait on the memory read port.
//   Result path: the last character passes the front stage register, the
//   queue and the back end output register before the result shows.
//   Receiver stall: the back end holds only a last character while the
//   result register is full; other characters keep flowing, and the queue
//   and front stage then fill and drop item_ready.
//   Reset: clears sum, sign, pending number, stack depth and status; the
//   stack memory is not cleared, as entries are only used once written.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_add_sub_paren_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire iasp_pkg::in_t   item,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output iasp_pkg::out_t       result
);

  logic          f_valid;
  logic          f_ready;
  iasp_pkg::op_t f_op;
  logic          q_valid;
  logic          q_ready;
  iasp_pkg::op_t q_op;

  iasp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op         (f_op)
  );

  iasp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  iasp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op_ready     (q_ready),
    .op           (q_op),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

/* hw/rtl/iasp_checker.sv */
// ----------------------------------------------------------------------------
// iasp_checker
// Port-level assertions for the expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iasp_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            item_valid,
  input wire logic            item_ready,
  input wire logic            result_valid,
  input wire logic            result_ready,
  input wire iasp_pkg::out_t  result
);

  // Hold a stalled result word
  `ASSERT_NEXT(a_res_hold, clk, rst,
    result_valid && !result_ready, result_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_res_stable, clk, rst,
    result_valid && !result_ready, $stable(result), "result changed while stalled")

  // Come out of reset empty and ready
  `ASSERT_IMPLY(a_rst_empty, clk, rst,
    $past(rst), !result_valid, "result valid right after reset")
  `ASSERT_IMPLY(a_rst_ready, clk, rst,
    $past(rst), item_ready, "input not ready right after reset")

  // Never show a result on the first cycle a character could have entered
  `ASSERT_NEXT(a_no_early, clk, rst,
    !result_valid && !(item_valid && item_ready) && $past(rst), !result_valid,
    "result without any accepted word")

endmodule

bind infix_add_sub_paren_evaluator iasp_checker u_iasp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

/* sim/tb_infix_add_sub_paren_evaluator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_add_sub_paren_evaluator
// Self-checking bench for the add/sub/paren expression evaluator.
// Drives a short table of directed characters, then random expressions
// (well formed, broken, deep nesting and raw byte noise) one character per
// word. Each accepted word runs through a local evaluator that predicts the
// value and status word sent at the end of every expression.
// ----------------------------------------------------------------------------

module tb_infix_add_sub_paren_evaluator;

  localparam int STACK_DEPTH = 64;
  localparam int DIR_N       = 25;
  localparam int RAND_ITEMS  = 1825;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic           clk;
  logic           rst;
  logic           item_valid;
  logic           item_ready;
  iasp_pkg::in_t  item;
  logic           result_valid;
  logic           result_ready;
  iasp_pkg::out_t result;

  infix_add_sub_paren_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Directed characters; typed expectation only where the answer is obvious
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic [31:0] value;
    logic        status;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{iasp_pkg::CH_NINE,         1'b1, 1'b1, 32'd9, 1'b0},
    // close with nothing open is dropped
    '{iasp_pkg::CH_CLOSE,        1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd3,  1'b1, 1'b1, 32'd3, 1'b0},
    '{iasp_pkg::CH_PLUS,         1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO,         1'b1, 1'b1, 32'd0, 1'b0},
    // unknown bytes split numbers and do nothing else
    '{8'h00,                     1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd4,  1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hFF,                     1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd2,  1'b1, 1'b1, 32'd6, 1'b0},
    // -(5-)2 : minus sign survives the close
    '{iasp_pkg::CH_MINUS,        1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_OPEN,         1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd5,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_MINUS,        1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_CLOSE,        1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd2,  1'b1, 1'b0, 32'd0, 1'b0},
    // 4294967297 wraps to 1
    '{iasp_pkg::CH_ZERO + 8'd4,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd2,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd9,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd4,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd9,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd6,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd7,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd2,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd9,  1'b0, 1'b0, 32'd0, 1'b0},
    '{iasp_pkg::CH_ZERO + 8'd7,  1'b1, 1'b1, 32'd1, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Expression evaluator (prediction)
  // --------------------------------------------------------------------------
  logic [iasp_pkg::WORD_W-1:0] acc_sum;
  logic                        add_mode;
  logic [iasp_pkg::WORD_W-1:0] num_acc;
  logic                        num_open;
  int                          nest;
  logic [iasp_pkg::WORD_W-1:0] frame_sum [STACK_DEPTH];
  logic                        frame_add [STACK_DEPTH];
  logic                        full_hit;

  function automatic void clear_eval();
    acc_sum  = '0;
    add_mode = 1'b1;
    num_acc  = '0;
    num_open = 1'b0;
    nest     = 0;
    full_hit = 1'b0;
  endfunction

  // Fold the number being typed into the sum with the current sign
  function automatic void fold_number();
    if (num_open) begin
      if (add_mode) acc_sum = acc_sum + num_acc;
      else          acc_sum = acc_sum - num_acc;
    end
    num_acc  = '0;
    num_open = 1'b0;
  endfunction

  function automatic bit eval_char(input logic [7:0] c, input logic fin,
                                   output iasp_pkg::out_t res);
    res = '0;
    if (c >= iasp_pkg::CH_ZERO && c <= iasp_pkg::CH_NINE) begin
      num_acc  = num_acc * 32'd10 + 32'(c - iasp_pkg::CH_ZERO);
      num_open = 1'b1;
    end else begin
      fold_number();
      case (c)
        iasp_pkg::CH_OPEN: begin
          if (nest < STACK_DEPTH) begin
            frame_sum[nest] = acc_sum;
            frame_add[nest] = add_mode;
            nest++;
            acc_sum  = '0;
            add_mode = 1'b1;
          end else begin
            full_hit = 1'b1;
          end
        end
        iasp_pkg::CH_CLOSE: begin
          if (nest > 0) begin
            nest--;
            if (frame_add[nest]) acc_sum = frame_sum[nest] + acc_sum;
            else                 acc_sum = frame_sum[nest] - acc_sum;
          end
        end
        iasp_pkg::CH_MINUS: add_mode = 1'b0;
        iasp_pkg::CH_PLUS:  add_mode = 1'b1;
        default: ;
      endcase
    end
    if (!fin) return 1'b0;
    fold_number();
    res.value  = acc_sum;
    res.status = full_hit;
    clear_eval();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted words, check returned results
  // --------------------------------------------------------------------------
  iasp_pkg::out_t expr_result_q [$];
  int             words_in;
  int             results_seen;
  int             mismatches;

  initial begin
    clear_eval();
    words_in     = 0;
    results_seen = 0;
    mismatches   = 0;
  end

  always @(posedge clk) begin : monitor
    iasp_pkg::out_t pred;
    iasp_pkg::out_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (eval_char(item.char_code, item.last, pred)) begin
          if (words_in < DIR_N && dir_rows[words_in].typed) begin
            pred.value  = dir_rows[words_in].value;
            pred.status = dir_rows[words_in].status;
          end
          expr_result_q.push_back(pred);
        end
        words_in++;
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (expr_result_q.size() == 0) begin
          $error("result with no expression pending: value %0d status %0b",
                 result.value, result.status);
          mismatches++;
        end else begin
          want = expr_result_q.pop_front();
          if (result.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, result.value);
            mismatches++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, result.status);
            mismatches++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Expression builders
  // --------------------------------------------------------------------------
  logic [7:0] expr_buf [$];

  function automatic void add_number();
    string big;
    int    r;
    int    nd;
    big = "4294967295";
    r   = $urandom_range(0, 19);
    if (r == 0) begin
      for (int i = 0; i < big.len(); i++) expr_buf.push_back(big[i]);
    end else begin
      nd = (r < 3) ? $urandom_range(8, 14) : $urandom_range(1, 3);
      repeat (nd) expr_buf.push_back(iasp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_sign();
    expr_buf.push_back($urandom_range(0, 1) ? iasp_pkg::CH_PLUS : iasp_pkg::CH_MINUS);
  endfunction

  // Balanced expression with optional unary minus and spaces
  function automatic void gen_well_formed();
    int budget;
    int depth;
    int max_open;
    bit want_term;
    budget    = $urandom_range(1, 12);
    max_open  = $urandom_range(0, 5);
    depth     = 0;
    want_term = 1'b1;
    if ($urandom_range(0, 4) == 0) expr_buf.push_back(iasp_pkg::CH_MINUS);
    forever begin
      if (want_term) begin
        if (budget > 0 && depth < max_open && $urandom_range(0, 3) == 0) begin
          expr_buf.push_back(iasp_pkg::CH_OPEN);
          depth++;
          if ($urandom_range(0, 3) == 0) expr_buf.push_back(iasp_pkg::CH_MINUS);
        end else begin
          add_number();
          want_term = 1'b0;
        end
      end else if (depth > 0 && (budget <= 0 || $urandom_range(0, 3) == 0)) begin
        expr_buf.push_back(iasp_pkg::CH_CLOSE);
        depth--;
      end else if (budget <= 0) begin
        break;
      end else begin
        add_sign();
        want_term = 1'b1;
      end
      budget--;
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(CH_SPACE);
    end
  endfunction

  // Nest close to, at, or past the stack depth, then unwind
  function automatic void gen_deep(input int levels);
    int extra;
    extra = $urandom_range(0, 2);
    for (int i = 0; i < levels; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_number();
        add_sign();
      end
      expr_buf.push_back(iasp_pkg::CH_OPEN);
    end
    add_number();
    for (int i = 0; i < levels + extra; i++) begin
      expr_buf.push_back(iasp_pkg::CH_CLOSE);
      if ($urandom_range(0, 7) == 0) begin
        add_sign();
        add_number();
      end
    end
  endfunction

  // Break a balanced expression with stray parens, bytes or a dropped char
  function automatic void mutate_expr();
    int pos;
    int pick;
    repeat ($urandom_range(1, 2)) begin
      pos  = $urandom_range(0, expr_buf.size() - 1);
      pick = $urandom_range(0, 3);
      if (pick == 0)      expr_buf.insert(pos, iasp_pkg::CH_CLOSE);
      else if (pick == 1) expr_buf.insert(pos, iasp_pkg::CH_OPEN);
      else if (pick == 2) expr_buf.insert(pos, 8'($urandom_range(0, 255)));
      else if (expr_buf.size() > 1) expr_buf.delete(pos);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of words with random gaps
  // --------------------------------------------------------------------------
  int burst_left;

  task automatic send_word(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= '{char_code: c, last: fin};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int  active_sent;
    int  n_expr;
    int  deep_cnt;
    int  pick;
    logic [7:0] c;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    burst_left  = 0;
    active_sent = 0;
    n_expr      = 0;
    deep_cnt    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed rows
    for (int i = 0; i < DIR_N; i++) send_word(dir_rows[i].ch, dir_rows[i].last);

    // Random expressions until enough words went in
    while (active_sent < RAND_ITEMS) begin
      expr_buf.delete();
      if (n_expr % 60 == 30) begin
        gen_deep(deep_cnt == 0 ? STACK_DEPTH + 1 :
                 deep_cnt == 1 ? STACK_DEPTH : $urandom_range(60, 72));
        deep_cnt++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          gen_well_formed();
        end else if (pick < 82) begin
          gen_well_formed();
          mutate_expr();
        end else begin
          repeat ($urandom_range(1, 10)) expr_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (int i = 0; i < expr_buf.size(); i++) begin
        c = expr_buf[i];
        send_word(c, i == expr_buf.size() - 1);
        active_sent++;
      end
      n_expr++;
    end
    item_valid <= 1'b0;

    // Drain, then let the pipeline settle for anything stray
    while (expr_result_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expr_result_q.size() == 0) begin
      $display("tb_infix_add_sub_paren_evaluator: PASS");
    end else begin
      $display("tb_infix_add_sub_paren_evaluator: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern plus one long hold-off to back up the input
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int span;
    bit held;
    result_ready = 1'b0;
    held         = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= ($urandom_range(0, 99) < 60);
          default: result_ready <= ((i % 7) < 2);
        endcase
        @(negedge clk);
      end
    end
  end

  // Hard stop in case the handshake hangs
  initial begin : watchdog
    #5000000;
    $display("tb_infix_add_sub_paren_evaluator: FAIL");
    $finish;
  end

endmodule
